[rtl/jstrm_pkg.sv]
// jstrm_pkg: shared types and codes for the job slot tracker and reply matcher
// no dependencies; used by every module under rtl except jstrm_ram

package jstrm_pkg;

  // operation codes of an incoming transaction
  localparam logic OP_DISPATCH = 1'b0;
  localparam logic OP_REPLY    = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_DISPATCH = 2'd0;
  localparam logic [1:0] STATUS_ACCEPT   = 2'd1;
  localparam logic [1:0] STATUS_REJECT   = 2'd2;

  // fixed field widths
  localparam int JOB_ID_W   = 7;
  localparam int SLOT_MAX_W = 8;
  localparam int ROLL_SHIFT = 13;

  // input transaction
  typedef struct packed {
    logic        operation;
    logic [31:0] job_version;
    logic [7:0]  reply_job_byte;
    logic [31:0] reply_nonce;
    logic [15:0] reply_version_raw;
  } req_t;

  // result transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  job_slot_id;
    logic [31:0] nonce_out;
    logic [31:0] merged_version;
  } rsp_t;

  // classified work item passed from front to back
  typedef struct packed {
    logic                  is_reply;
    logic                  hit;
    logic [JOB_ID_W-1:0]   job_id;
    logic [SLOT_MAX_W-1:0] slot;
    logic [31:0]           data;
    logic [31:0]           roll_bits;
  } work_t;

endpackage

[rtl/job_slot_tracker_result_matcher.sv]
// A dispatch or a rejected reply passes the queue and the result register on its way out,
// an accepted reply also the registered version RAM read.
// Dispatches and rejected replies flow at one transaction per cycle while the result register
// is free; an accepted reply holds the back end in its read state until its result is loaded.
// Reset clears the job id counter, the slot valid bits, the queue and the result valid
// flag; version RAM contents are not cleared and are only read once written.

module job_slot_tracker_result_matcher #(
  parameter int ID_SPACE = 128,
  parameter int ID_STEP  = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  jstrm_pkg::req_t req_data,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output jstrm_pkg::rsp_t rsp_data
);

  localparam int NUM_SLOTS = (ID_SPACE + ID_STEP - 1) / ID_STEP;

  logic             push_valid;
  logic             push_ready;
  jstrm_pkg::work_t push_data;
  logic             work_valid;
  logic             work_pop;
  jstrm_pkg::work_t work;

  // accept and classify
  jstrm_front #(
    .ID_SPACE(ID_SPACE),
    .ID_STEP (ID_STEP)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  // decoupling queue
  jstrm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (work_valid),
    .pop       (work_pop),
    .pop_data  (work)
  );

  // execute and return results
  jstrm_back #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .work_valid(work_valid),
    .work_pop  (work_pop),
    .work      (work),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

[rtl/jstrm_ram.sv]
// jstrm_ram: generic single write port, single read port RAM with registered read
// no dependencies

module jstrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/jstrm_front.sv]
// jstrm_front: accepts transactions, assigns dispatch ids, tracks slot valid bits
// and classifies replies as hit or miss; depends on jstrm_pkg

module jstrm_front #(
  parameter int ID_SPACE = 128,
  parameter int ID_STEP  = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  jstrm_pkg::req_t     req_data,
  output logic                push_valid,
  input  logic                push_ready,
  output jstrm_pkg::work_t    push_data
);

  localparam int NUM_SLOTS = (ID_SPACE + ID_STEP - 1) / ID_STEP;
  localparam int SLOT_W    = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
  localparam int ID_W      = $clog2(ID_SPACE);
  localparam int SUM_W     = $clog2(2 * ID_SPACE);
  localparam int LAST_W    = ID_W < jstrm_pkg::JOB_ID_W ? ID_W : jstrm_pkg::JOB_ID_W;

  logic [LAST_W-1:0]    last_job_id;
  logic [NUM_SLOTS-1:0] slot_valid;

  logic [7:0]  div_lut   [256];
  logic [7:0]  floor_lut [256];

  logic [SUM_W-1:0] id_sum;
  logic [ID_W-1:0]  disp_id;
  logic [7:0]       disp_slot;
  logic [7:0]       reply_id;
  logic [7:0]       reply_slot;
  logic             reply_in_range;
  logic             reply_hit;
  logic [15:0]      ver_swapped;
  logic             accept;

  // constant tables: slot index and id rounded down to a multiple of the step
  for (genvar v = 0; v < 256; v++) begin : g_lut
    assign div_lut[v]   = 8'(v / ID_STEP);
    assign floor_lut[v] = 8'(v - (v % ID_STEP));
  end

  // next dispatch id, wrapped by one conditional subtract
  always_comb begin
    id_sum = SUM_W'(last_job_id) + SUM_W'(ID_STEP);
    if (id_sum >= SUM_W'(ID_SPACE)) begin
      disp_id = ID_W'(id_sum - SUM_W'(ID_SPACE));
    end else begin
      disp_id = ID_W'(id_sum);
    end
    disp_slot = div_lut[8'(disp_id)];
  end

  // reply classification
  always_comb begin
    reply_id       = floor_lut[req_data.reply_job_byte];
    reply_slot     = div_lut[req_data.reply_job_byte];
    reply_in_range = {1'b0, reply_id} < 9'(ID_SPACE);
    reply_hit      = reply_in_range && slot_valid[reply_slot[SLOT_W-1:0]];
    ver_swapped    = {req_data.reply_version_raw[7:0], req_data.reply_version_raw[15:8]};
  end

  // work item toward the queue
  always_comb begin
    push_valid = req_valid;
    req_ready  = push_ready;
    accept     = req_valid && push_ready;
    push_data  = '0;
    if (req_data.operation == jstrm_pkg::OP_REPLY) begin
      push_data.is_reply  = 1'b1;
      push_data.hit       = reply_hit;
      push_data.job_id    = jstrm_pkg::JOB_ID_W'(reply_id);
      push_data.slot      = reply_slot;
      push_data.data      = req_data.reply_nonce;
      push_data.roll_bits = 32'(ver_swapped) << jstrm_pkg::ROLL_SHIFT;
    end else begin
      push_data.is_reply  = 1'b0;
      push_data.hit       = 1'b0;
      push_data.job_id    = jstrm_pkg::JOB_ID_W'(disp_id);
      push_data.slot      = disp_slot;
      push_data.data      = req_data.job_version;
      push_data.roll_bits = '0;
    end
  end

  // id counter and slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      last_job_id <= '0;
      slot_valid  <= '0;
    end else if (accept && req_data.operation == jstrm_pkg::OP_DISPATCH) begin
      last_job_id                       <= LAST_W'(disp_id);
      slot_valid[disp_slot[SLOT_W-1:0]] <= 1'b1;
    end
  end

endmodule

[rtl/jstrm_queue.sv]
// jstrm_queue: two-entry queue of classified work items between front and back
// depends on jstrm_pkg

module jstrm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  jstrm_pkg::work_t push_data,
  output logic             pop_valid,
  input  logic             pop,
  output jstrm_pkg::work_t pop_data
);

  jstrm_pkg::work_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[rtl/jstrm_back.sv]
// jstrm_back: executes work items against the version RAM and holds the result register
// depends on jstrm_pkg and jstrm_ram

module jstrm_back #(
  parameter int NUM_SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             work_valid,
  output logic             work_pop,
  input  jstrm_pkg::work_t work,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output jstrm_pkg::rsp_t  rsp_data
);

  localparam int SLOT_W = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;

  // back end states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state;
  logic state_next;

  logic                         out_free;
  logic                         load;
  jstrm_pkg::rsp_t              rsp_next;
  logic [jstrm_pkg::JOB_ID_W-1:0] pend_id;
  logic [31:0]                  pend_nonce;
  logic [31:0]                  pend_bits;
  logic                         ram_we;
  logic                         ram_re;
  logic [31:0]                  ram_rdata;

  // version store
  jstrm_ram #(
    .WIDTH(32),
    .DEPTH(NUM_SLOTS)
  ) u_version_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(work.slot[SLOT_W-1:0]),
    .wdata(work.data),
    .re   (ram_re),
    .raddr(work.slot[SLOT_W-1:0]),
    .rdata(ram_rdata)
  );

  // pop, memory access and result selection
  always_comb begin
    out_free   = !rsp_valid || rsp_ready;
    work_pop   = (state == ST_IDLE) && work_valid && out_free;
    ram_we     = work_pop && !work.is_reply;
    ram_re     = work_pop && work.is_reply && work.hit;
    load       = 1'b0;
    state_next = state;
    rsp_next   = '0;
    unique case (state)
      ST_IDLE: begin
        if (ram_re) begin
          state_next = ST_READ;
        end else if (work_pop) begin
          load                 = 1'b1;
          rsp_next.job_slot_id = work.job_id;
          rsp_next.status      = work.is_reply ? jstrm_pkg::STATUS_REJECT
                                               : jstrm_pkg::STATUS_DISPATCH;
        end
      end
      ST_READ: begin
        rsp_next.status         = jstrm_pkg::STATUS_ACCEPT;
        rsp_next.job_slot_id    = pend_id;
        rsp_next.nonce_out      = pend_nonce;
        rsp_next.merged_version = ram_rdata | pend_bits;
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // fields of a hit held during the memory read
  always_ff @(posedge clk) begin
    if (ram_re) begin
      pend_id    <= work.job_id;
      pend_nonce <= work.data;
      pend_bits  <= work.roll_bits;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      rsp_data <= rsp_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/jstrm_checker.sv]
// jstrm_checker: port-level checks of the job slot tracker, bound to the top level
// depends on jstrm_pkg and job_slot_tracker_result_matcher

module jstrm_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input jstrm_pkg::req_t req_data,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input jstrm_pkg::rsp_t rsp_data
);

  // no result is shown right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a stalled request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req_data))
    else $error("stalled request changed");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed");

  // only the three defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.status == jstrm_pkg::STATUS_DISPATCH ||
                   rsp_data.status == jstrm_pkg::STATUS_ACCEPT ||
                   rsp_data.status == jstrm_pkg::STATUS_REJECT))
    else $error("undefined status code");

  // dispatch and rejected results carry no nonce or version
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != jstrm_pkg::STATUS_ACCEPT |->
      rsp_data.nonce_out == 32'd0 && rsp_data.merged_version == 32'd0)
    else $error("non-accept result carries payload");

endmodule

bind job_slot_tracker_result_matcher jstrm_checker u_jstrm_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req_data (req_data),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp_data (rsp_data)
);

[tb/job_slot_tracker_result_matcher_tb.sv]
// job_slot_tracker_result_matcher_tb: self-checking testbench for the job slot tracker
// depends on jstrm_pkg and job_slot_tracker_result_matcher under rtl; predicts every
// result from its own copy of the slot table and checks each result transaction in order
`timescale 1ns / 100ps

module job_slot_tracker_result_matcher_tb;

  localparam int ID_SPACE   = 128;
  localparam int ID_STEP    = 8;
  localparam int NUM_SLOTS  = ID_SPACE / ID_STEP;
  localparam int RAND_ITEMS = 1550;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  jstrm_pkg::req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  jstrm_pkg::rsp_t rsp_data;

  job_slot_tracker_result_matcher #(
    .ID_SPACE(ID_SPACE),
    .ID_STEP (ID_STEP)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  jstrm_pkg::req_t job_traffic_q[$];
  jstrm_pkg::rsp_t tracker_results_q[$];
  int   total_items;
  int   accepted_cnt = 0;
  int   n_mismatch   = 0;

  // mirror of the tracker state
  logic [6:0]  last_id;
  logic        slot_live[NUM_SLOTS];
  logic [31:0] slot_ver[NUM_SLOTS];

  // apply one transaction to the mirror and return the result it should produce
  function automatic jstrm_pkg::rsp_t tracker_step(jstrm_pkg::req_t t);
    jstrm_pkg::rsp_t r;
    int          nid;
    logic [7:0]  masked;
    logic [15:0] swapped;
    int          slot;
    r = '0;
    if (t.operation == jstrm_pkg::OP_DISPATCH) begin
      nid = (int'(last_id) + ID_STEP) % ID_SPACE;
      last_id = 7'(nid);
      slot_ver[nid / ID_STEP]  = t.job_version;
      slot_live[nid / ID_STEP] = 1'b1;
      r.status      = jstrm_pkg::STATUS_DISPATCH;
      r.job_slot_id = 7'(nid);
    end else begin
      masked = 8'(t.reply_job_byte - (t.reply_job_byte % ID_STEP));
      slot   = int'(masked) / ID_STEP;
      r.job_slot_id = masked[6:0];
      r.status      = jstrm_pkg::STATUS_REJECT;
      if (int'(masked) < ID_SPACE && slot_live[slot]) begin
        swapped          = {t.reply_version_raw[7:0], t.reply_version_raw[15:8]};
        r.status         = jstrm_pkg::STATUS_ACCEPT;
        r.nonce_out      = t.reply_nonce;
        r.merged_version = slot_ver[slot] | (32'(swapped) << jstrm_pkg::ROLL_SHIFT);
      end
    end
    return r;
  endfunction

  // unused fields carry random noise
  function automatic jstrm_pkg::req_t dispatch_item(logic [31:0] ver);
    jstrm_pkg::req_t t;
    t.operation         = jstrm_pkg::OP_DISPATCH;
    t.job_version       = ver;
    t.reply_job_byte    = 8'($urandom);
    t.reply_nonce       = $urandom;
    t.reply_version_raw = 16'($urandom);
    return t;
  endfunction

  function automatic jstrm_pkg::req_t reply_item(logic [7:0] jbyte, logic [31:0] nonce,
                                                 logic [15:0] rver);
    jstrm_pkg::req_t t;
    t.operation         = jstrm_pkg::OP_REPLY;
    t.job_version       = $urandom;
    t.reply_job_byte    = jbyte;
    t.reply_nonce       = nonce;
    t.reply_version_raw = rver;
    return t;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t ns: %s", $time, what);
    n_mismatch++;
  endtask

  // idle rates per phase: sender-heavy, receiver-heavy, then none
  function automatic int idle_pct(bit sender);
    if (accepted_cnt < total_items / 3) return sender ? 36 : 54;
    if (accepted_cnt < 2 * total_items / 3) return sender ? 54 : 36;
    return 0;
  endfunction

  // stimulus and end of run
  initial begin
    last_id = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_ver[i]  = '0;
    end

    // replies before any dispatch, then the first ids, masking and out of range ids
    job_traffic_q.push_back(reply_item(8'd0, $urandom, 16'($urandom)));
    job_traffic_q.push_back(reply_item(8'd127, $urandom, 16'($urandom)));
    job_traffic_q.push_back(dispatch_item(32'h0000_0000));
    job_traffic_q.push_back(dispatch_item(32'hffff_ffff));
    job_traffic_q.push_back(reply_item(8'd8, 32'hffff_ffff, 16'hffff));
    job_traffic_q.push_back(reply_item(8'd15, 32'h0000_0000, 16'h0000));
    job_traffic_q.push_back(reply_item(8'd16, $urandom, 16'h0001));
    job_traffic_q.push_back(reply_item(8'd24, $urandom, 16'h8000));
    job_traffic_q.push_back(reply_item(8'd128, $urandom, 16'($urandom)));
    job_traffic_q.push_back(reply_item(8'd255, $urandom, 16'($urandom)));
    // run the id around to zero
    for (int i = 0; i < 14; i++) job_traffic_q.push_back(dispatch_item($urandom));
    job_traffic_q.push_back(reply_item(8'd0, $urandom, 16'($urandom)));
    job_traffic_q.push_back(reply_item(8'd7, $urandom, 16'($urandom)));

    // random mix: mostly replies to in range ids, some to fully random bytes
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 40) begin
        job_traffic_q.push_back(dispatch_item($urandom));
      end else if ($urandom_range(0, 99) < 75) begin
        job_traffic_q.push_back(reply_item({1'b0, 4'($urandom), 3'($urandom)},
                                           $urandom, 16'($urandom)));
      end else begin
        job_traffic_q.push_back(reply_item(8'($urandom), $urandom, 16'($urandom)));
      end
    end
    total_items = job_traffic_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (job_traffic_q.size() != 0 || req_valid) @(posedge clk);
    while (tracker_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // driver: offers queued transactions, predicts each one as it is accepted
  always @(posedge clk) begin
    bit free;
    if (rst) begin
      req_valid <= 1'b0;
      req_data  <= '0;
    end else begin
      free = !req_valid;
      if (req_valid && req_ready) begin
        tracker_results_q.push_back(tracker_step(req_data));
        accepted_cnt <= accepted_cnt + 1;
        free = 1'b1;
      end
      if (free) begin
        if (job_traffic_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          req_valid <= 1'b1;
          req_data  <= job_traffic_q.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off so the block backs up
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (!hold_done && accepted_cnt >= 300) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    jstrm_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (tracker_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", rsp_data));
      end else begin
        want = tracker_results_q.pop_front();
        if (rsp_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    rsp_data.status, want.status));
        if (rsp_data.job_slot_id !== want.job_slot_id)
          report_mismatch($sformatf("job_slot_id got %0d want %0d",
                                    rsp_data.job_slot_id, want.job_slot_id));
        if (rsp_data.nonce_out !== want.nonce_out)
          report_mismatch($sformatf("nonce_out got %h want %h",
                                    rsp_data.nonce_out, want.nonce_out));
        if (rsp_data.merged_version !== want.merged_version)
          report_mismatch($sformatf("merged_version got %h want %h",
                                    rsp_data.merged_version, want.merged_version));
      end
    end
  end

  // watchdog: too many cycles without any transaction
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
